// ===== sv/isc_pkg.sv =====
package isc_pkg;

	typedef struct packed {
		logic        valid;
		logic        in_use;
		logic        locked;
		logic        wanted;
		logic [3:0]  fs;
		logic [15:0] inode;
		logic [7:0]  count;
	} entry_t;

	typedef struct packed {
		logic found;
		logic free_hi;
		logic free_any;
	} scan_flags_t;

	typedef enum logic [2:0] {
		ST_HIT_IDLE = 3'd0,
		ST_HIT_OPEN = 3'd1,
		ST_MISS     = 3'd2,
		ST_RETRY    = 3'd3,
		ST_FULL     = 3'd4,
		ST_REL_LAST = 3'd5,
		ST_REL      = 3'd6
	} status_t;

	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage

// ===== sv/isc_mem.sv =====
module isc_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  isc_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output isc_pkg::entry_t   rdata
);
	import isc_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/isc_scan.sv =====
module isc_scan #(
	parameter int AW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  vld,
	input  logic [AW-1:0]         idx,
	input  isc_pkg::entry_t       ent,
	input  logic [3:0]            fs_id,
	input  logic [15:0]           inode_number,
	input  logic [AW:0]           start_ptr,
	output isc_pkg::scan_flags_t  flags,
	output logic [AW-1:0]         match_idx,
	output isc_pkg::entry_t       match_ent,
	output logic [AW-1:0]         free_hi_idx,
	output logic [AW-1:0]         free_any_idx
);
	import isc_pkg::*;

	scan_flags_t   flags_q;
	logic [AW-1:0] match_idx_q;
	entry_t        match_ent_q;
	logic [AW-1:0] free_hi_idx_q;
	logic [AW-1:0] free_any_idx_q;
	logic          hit;
	logic          is_free;
	logic          at_or_above;

	assign hit         = ent.valid && (ent.fs == fs_id) && (ent.inode == inode_number);
	assign is_free     = !ent.in_use;
	assign at_or_above = ({1'b0, idx} >= start_ptr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else if (vld) begin
			if (hit && !flags_q.found) begin
				flags_q.found <= 1'b1;
			end
			if (is_free && !flags_q.free_any) begin
				flags_q.free_any <= 1'b1;
			end
			if (is_free && at_or_above && !flags_q.free_hi) begin
				flags_q.free_hi <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld && !clr) begin
			if (hit && !flags_q.found) begin
				match_idx_q <= idx;
				match_ent_q <= ent;
			end
			if (is_free && !flags_q.free_any) begin
				free_any_idx_q <= idx;
			end
			if (is_free && at_or_above && !flags_q.free_hi) begin
				free_hi_idx_q <= idx;
			end
		end
	end

	assign flags        = flags_q;
	assign match_idx    = match_idx_q;
	assign match_ent    = match_ent_q;
	assign free_hi_idx  = free_hi_idx_q;
	assign free_any_idx = free_any_idx_q;

endmodule

// ===== sv/inode_slot_cache_manager.sv =====
// Inode slot cache: a fully associative table of SLOTS slots keyed by filesystem id and
// inode number, held in one synchronous memory of one word per slot. Assert start for one
// cycle while busy is low; the word is taken at that edge. An acquire reads every slot once,
// one memory read per cycle, and then writes the chosen slot back, if there is one; a release
// reads one slot and, if slot_index is within SLOTS, writes it back. Each result appears for
// exactly one cycle with done high, in the cycle after its write-back, and must be captured
// then: there is no way to hold it off. After reset the block clears every memory word, busy
// high, before taking any word.
module inode_slot_cache_manager #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [3:0]  fs_id,
	input  logic [15:0] inode_number,
	input  logic [5:0]  slot_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  slot,
	output logic        wake,
	output logic [7:0]  use_count
);
	import isc_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int XW = ((AW > 6) ? AW : 6) + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_REL_RD,
		S_REL
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic [3:0]    key_fs_q;
	logic [15:0]   key_ino_q;
	logic [5:0]    rel_idx_q;
	logic [AW:0]   start_q;
	logic [AW:0]   search_start_q;
	logic [31:0]   hit_total_q;
	logic [31:0]   miss_total_q;
	logic          done_q;
	status_t       status_q;
	logic [5:0]    slot_q;
	logic          wake_q;
	logic [7:0]    count_q;

	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	scan_flags_t   flags;
	logic [AW-1:0] match_idx;
	entry_t        match_ent;
	logic [AW-1:0] free_hi_idx;
	logic [AW-1:0] free_any_idx;
	logic [AW-1:0] free_idx;
	logic          match_hi;

	logic [XW-1:0] rel_x;
	logic [AW-1:0] rel_addr;
	logic          rel_in_range;

	logic          accept;
	entry_t        ent_w;
	status_t       res_status;
	logic [5:0]    res_slot;
	logic          res_wake;
	logic [7:0]    res_count;
	logic [AW:0]   ss_next;
	logic          hit_inc;
	logic          miss_inc;

	assign accept       = start && (state_q == S_IDLE);
	assign busy         = (state_q != S_IDLE);
	assign rel_x        = XW'(rel_idx_q);
	assign rel_addr     = rel_x[AW-1:0];
	assign rel_in_range = (rel_x < XW'(SLOTS));
	assign match_hi     = ({1'b0, match_idx} >= start_q);
	assign free_idx     = flags.free_hi ? free_hi_idx : free_any_idx;

	assign mem_re    = (state_q == S_SCAN) || (state_q == S_REL_RD);
	assign mem_raddr = (state_q == S_SCAN) ? cnt_q : rel_addr;

	isc_mem #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	isc_scan #(
		.AW (AW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr          (accept),
		.vld          (rd_vld_s1),
		.idx          (rd_idx_s1),
		.ent          (mem_rdata),
		.fs_id        (key_fs_q),
		.inode_number (key_ino_q),
		.start_ptr    (start_q),
		.flags        (flags),
		.match_idx    (match_idx),
		.match_ent    (match_ent),
		.free_hi_idx  (free_hi_idx),
		.free_any_idx (free_any_idx)
	);

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = cnt_q;
		mem_wdata  = '0;
		ent_w      = match_ent;
		res_status = ST_REL;
		res_slot   = '0;
		res_wake   = 1'b0;
		res_count  = '0;
		ss_next    = search_start_q;
		hit_inc    = 1'b0;
		miss_inc   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = '0;
			end
			S_DECIDE: begin
				if (flags.found) begin
					if (!match_hi) begin
						ss_next = '0;
					end
					mem_we    = 1'b1;
					mem_waddr = match_idx;
					res_slot  = 6'(match_idx);
					if (match_ent.locked) begin
						ent_w.wanted = 1'b1;
						res_status   = ST_RETRY;
						res_count    = match_ent.count;
					end else begin
						res_status = match_ent.in_use ? ST_HIT_OPEN : ST_HIT_IDLE;
						hit_inc    = !match_ent.in_use;
						if (match_ent.count != COUNT_MAX) begin
							ent_w.count = match_ent.count + 8'd1;
						end
						ent_w.locked = 1'b1;
						ent_w.in_use = 1'b1;
						res_count    = ent_w.count;
					end
					mem_wdata = ent_w;
				end else begin
					if (start_q != '0) begin
						ss_next = '0;
					end
					if (flags.free_hi || flags.free_any) begin
						ent_w.valid  = 1'b1;
						ent_w.in_use = 1'b1;
						ent_w.locked = 1'b1;
						ent_w.wanted = 1'b0;
						ent_w.fs     = key_fs_q;
						ent_w.inode  = key_ino_q;
						ent_w.count  = 8'd1;
						mem_we       = 1'b1;
						mem_waddr    = free_idx;
						mem_wdata    = ent_w;
						ss_next      = {1'b0, free_idx} + (AW+1)'(1);
						miss_inc     = 1'b1;
						res_status   = ST_MISS;
						res_slot     = 6'(free_idx);
						res_count    = 8'd1;
					end else begin
						res_status = ST_FULL;
					end
				end
			end
			S_REL: begin
				res_slot = rel_idx_q;
				if (rel_in_range) begin
					ent_w    = mem_rdata;
					res_wake = mem_rdata.wanted;
					if (mem_rdata.count == 8'd1) begin
						ent_w.count  = '0;
						ent_w.in_use = 1'b0;
						res_status   = ST_REL_LAST;
					end else if (mem_rdata.count != '0) begin
						ent_w.count = mem_rdata.count - 8'd1;
					end
					ent_w.locked = 1'b0;
					ent_w.wanted = 1'b0;
					res_count    = ent_w.count;
					mem_we       = 1'b1;
					mem_waddr    = rel_addr;
					mem_wdata    = ent_w;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			cnt_q          <= '0;
			search_start_q <= '0;
			hit_total_q    <= '0;
			miss_total_q   <= '0;
			done_q         <= 1'b0;
			status_q       <= ST_HIT_IDLE;
			slot_q         <= '0;
			wake_q         <= 1'b0;
			count_q        <= '0;
			start_q        <= '0;
			key_fs_q       <= '0;
			key_ino_q      <= '0;
			rel_idx_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == AW'(SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						key_fs_q  <= fs_id;
						key_ino_q <= inode_number;
						rel_idx_q <= slot_index;
						start_q   <= search_start_q;
						cnt_q     <= '0;
						state_q   <= (kind == KIND_RELEASE) ? S_REL_RD : S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == AW'(SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					search_start_q <= ss_next;
					if (hit_inc) begin
						hit_total_q <= hit_total_q + 32'd1;
					end
					if (miss_inc) begin
						miss_total_q <= miss_total_q + 32'd1;
					end
					done_q   <= 1'b1;
					status_q <= res_status;
					slot_q   <= res_slot;
					wake_q   <= res_wake;
					count_q  <= res_count;
					state_q  <= S_IDLE;
				end
				S_REL_RD: begin
					state_q <= S_REL;
				end
				S_REL: begin
					done_q   <= 1'b1;
					status_q <= res_status;
					slot_q   <= res_slot;
					wake_q   <= res_wake;
					count_q  <= res_count;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign wake      = wake_q;
	assign use_count = count_q;

endmodule
